FILE: rtl/tcpf_pkg.sv
// shared types and constants for the two-class priority fifo unit
// no dependencies; imported by every module of the block
package tcpf_pkg;

    localparam int TAG_W       = 16;
    localparam int TICKET_W    = 16;
    localparam int POS_W       = 6;
    localparam int DEPTH_DEF   = 32;
    localparam int POS_MAX     = 63;

    // command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SERVE   = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // one stored entry: tag in the upper half, ticket in the lower half
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [TICKET_W-1:0] ticket;
    } entry_t;

    // per-cycle request to one ring
    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

endpackage

FILE: rtl/tcpf_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// uses tcpf_pkg for the entry type
module tcpf_ram #(
    parameter int DEPTH  = tcpf_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  tcpf_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output tcpf_pkg::entry_t     rd_data
);
    import tcpf_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tcpf_ring.sv
// one circular queue: head, tail and count around a tcpf_ram
// depends on tcpf_pkg and tcpf_ram
module tcpf_ring #(
    parameter int DEPTH = tcpf_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcpf_pkg::ring_cmd_t cmd,
    input  tcpf_pkg::entry_t    wr_data,
    output logic [CNT_W-1:0]    count,
    output tcpf_pkg::entry_t    rd_data
);
    import tcpf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and occupancy update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry storage: push writes at the tail, pop reads at the head
    tcpf_ram #(
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (cmd.push),
        .wr_addr(tail_reg),
        .wr_data(wr_data),
        .rd_en  (cmd.pop),
        .rd_addr(head_reg),
        .rd_data(rd_data)
    );

    assign count = count_reg;

endmodule

FILE: rtl/two_class_priority_fifo_unit.sv
// two-class priority fifo unit: strict-priority pair of circular queues with tickets
// an accepted request waits in the pending registers and the ram read register, then moves to the output register
// no new request is taken until the pending result has moved into the output register
// a new request is taken while the previous result still waits in the output register
// reset: both queues empty, ticket counter at 1; ram contents are not cleared
module two_class_priority_fifo_unit #(
    parameter int QUEUE_DEPTH = tcpf_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic                           preferred,
    input  logic [tcpf_pkg::TAG_W-1:0]     customer_tag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [tcpf_pkg::TICKET_W-1:0]  ticket,
    output logic [tcpf_pkg::TAG_W-1:0]     served_tag,
    output logic                           from_priority,
    output logic [tcpf_pkg::POS_W-1:0]     queue_position
);
    import tcpf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_FILL
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] p_count, n_count;
    entry_t           p_rd, n_rd;
    entry_t           wr_entry;
    ring_cmd_t        p_cmd, n_cmd;

    logic             accept, do_enq, do_srv;
    logic             p_full, n_full, tgt_full;
    logic [CNT_W:0]   tgt_count_inc;
    logic [31:0]      tgt_count_wide;
    logic [POS_W-1:0] pos_sat;

    logic [TICKET_W-1:0] next_ticket_reg, next_ticket_next;

    // pending result captured at accept
    status_t             pend_status_reg;
    logic [TICKET_W-1:0] pend_ticket_reg;
    logic                pend_fromp_reg;
    logic [POS_W-1:0]    pend_pos_reg;
    logic                pend_rd_p_reg;
    logic                pend_rd_n_reg;

    // output register
    logic                out_valid_reg;
    status_t             status_reg;
    logic [TICKET_W-1:0] ticket_reg;
    logic [TAG_W-1:0]    served_tag_reg;
    logic                from_priority_reg;
    logic [POS_W-1:0]    queue_position_reg;
    logic                out_load;

    // request decode
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign do_enq   = accept && (command == CMD_ENQUEUE);
    assign do_srv   = accept && (command == CMD_SERVE);

    assign p_full   = (p_count == CNT_FULL);
    assign n_full   = (n_count == CNT_FULL);
    assign tgt_full = preferred ? p_full : n_full;

    // ring requests; serve prefers the priority queue
    always_comb
    begin
        p_cmd.push = do_enq && preferred && !p_full;
        n_cmd.push = do_enq && !preferred && !n_full;
        p_cmd.pop  = do_srv && (p_count != '0);
        n_cmd.pop  = do_srv && (p_count == '0) && (n_count != '0);
    end

    assign wr_entry.tag    = customer_tag;
    assign wr_entry.ticket = next_ticket_reg;

    // occupancy after a successful enqueue, saturated to the field width
    assign tgt_count_inc  = {1'b0, (preferred ? p_count : n_count)} + 1'b1;
    assign tgt_count_wide = 32'(tgt_count_inc);
    assign pos_sat = (tgt_count_wide > 32'(POS_MAX)) ? POS_W'(POS_MAX)
                                                     : tgt_count_wide[POS_W-1:0];

    assign next_ticket_next = do_enq ? next_ticket_reg + 1'b1 : next_ticket_reg;

    // output register can take the pending result
    assign out_load = (state_reg == S_FILL) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept)   state_next = S_FILL;
            S_FILL:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // queues
    tcpf_ring #(
        .DEPTH(QUEUE_DEPTH),
        .CNT_W(CNT_W)
    ) u_prio (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (p_cmd),
        .wr_data(wr_entry),
        .count  (p_count),
        .rd_data(p_rd)
    );

    tcpf_ring #(
        .DEPTH(QUEUE_DEPTH),
        .CNT_W(CNT_W)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (n_cmd),
        .wr_data(wr_entry),
        .count  (n_count),
        .rd_data(n_rd)
    );

    // pending result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_rd_p_reg <= p_cmd.pop;
            pend_rd_n_reg <= n_cmd.pop;
            pend_pos_reg  <= '0;
            if (command == CMD_ENQUEUE)
            begin
                pend_ticket_reg <= next_ticket_reg;
                pend_fromp_reg  <= preferred;
                if (tgt_full)
                begin
                    pend_status_reg <= ST_FULL;
                end
                else
                begin
                    pend_status_reg <= ST_ENQUEUED;
                    pend_pos_reg    <= pos_sat;
                end
            end
            else
            begin
                pend_ticket_reg <= '0;
                pend_fromp_reg  <= p_cmd.pop;
                pend_status_reg <= (p_cmd.pop || n_cmd.pop) ? ST_SERVED : ST_EMPTY;
            end
        end
    end

    // state, ticket counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            next_ticket_reg    <= TICKET_W'(1);
            out_valid_reg      <= 1'b0;
            status_reg         <= ST_ENQUEUED;
            ticket_reg         <= '0;
            served_tag_reg     <= '0;
            from_priority_reg  <= 1'b0;
            queue_position_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            next_ticket_reg <= next_ticket_next;
            if (out_load)
            begin
                out_valid_reg      <= 1'b1;
                status_reg         <= pend_status_reg;
                from_priority_reg  <= pend_fromp_reg;
                queue_position_reg <= pend_pos_reg;
                if (pend_rd_p_reg)
                begin
                    ticket_reg     <= p_rd.ticket;
                    served_tag_reg <= p_rd.tag;
                end
                else if (pend_rd_n_reg)
                begin
                    ticket_reg     <= n_rd.ticket;
                    served_tag_reg <= n_rd.tag;
                end
                else
                begin
                    ticket_reg     <= pend_ticket_reg;
                    served_tag_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign ticket         = ticket_reg;
    assign served_tag     = served_tag_reg;
    assign from_priority  = from_priority_reg;
    assign queue_position = queue_position_reg;

endmodule
